// ----- sv/mcrl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcrl_pkg
// Shared types, constants and helpers of the message cache with random or
// last-slot replacement.
// ----------------------------------------------------------------------------
package mcrl_pkg;

  localparam int LFSR_W     = 16;
  localparam int ID_W       = 31;
  localparam int HANDLE_W   = 32;
  localparam int SLOT_OUT_W = 4;
  localparam int FILL_OUT_W = 5;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  localparam logic [LFSR_W-1:0] SEED_DEFAULT = 16'd44257;
  localparam logic [LFSR_W-1:0] LFSR_TAPS    = 16'hB400;

  localparam logic [CFG_IDX_W-1:0] REG_REPLACE_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANDOM_SEED  = 1'd1;

  localparam logic KIND_ADD    = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_REDUCE,
    ST_ADD_RND,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [HANDLE_W-1:0] handle;
  } slot_entry_t;

  typedef struct packed {
    logic in_ready;
    logic wr_fill;
    logic wr_last;
    logic lfsr_step;
    logic red_step;
    logic wr_rem;
    logic scan;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_kind;
    logic full;
    logic lifo_mode;
    logic scan_match;
    logic scan_done;
    logic out_free;
  } dp_status_t;

  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] cur);
    logic [LFSR_W-1:0] nxt;
    nxt = cur >> 1;
    if (cur[0]) begin
      nxt = nxt ^ LFSR_TAPS;
    end
    return nxt;
  endfunction

endpackage
`default_nettype wire

// ----- sv/mcrl_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcrl_if
// Valid/ready channels for the request and result transactions.
// ----------------------------------------------------------------------------
interface mcrl_in_if
  import mcrl_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic                kind;
  logic [ID_W-1:0]     msg_id;
  logic [HANDLE_W-1:0] msg_handle;

  modport source (output valid, output kind, output msg_id, output msg_handle, input ready);
  modport sink   (input valid, input kind, input msg_id, input msg_handle, output ready);
endinterface

interface mcrl_out_if
  import mcrl_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [SLOT_OUT_W-1:0] slot;
  logic [HANDLE_W-1:0]   handle_out;
  logic                  replaced;
  logic [FILL_OUT_W-1:0] fill_level;

  modport source (output valid, output hit, output slot, output handle_out,
                  output replaced, output fill_level, input ready);
  modport sink   (input valid, input hit, input slot, input handle_out,
                  input replaced, input fill_level, output ready);
endinterface
`default_nettype wire

// ----- sv/mcrl_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcrl_ctrl
// Sequencer that steps the datapath through add, replacement and lookup.
// ----------------------------------------------------------------------------
module mcrl_ctrl
  import mcrl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (status.in_valid) begin
          state_nxt = (status.in_kind == KIND_ADD) ? ST_ADD : ST_SCAN;
        end
      end
      ST_ADD: begin
        if (!status.full || status.lifo_mode) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        state_nxt = ST_ADD_RND;
      end
      ST_ADD_RND: begin
        state_nxt = ST_EMIT;
      end
      ST_SCAN: begin
        if (status.scan_match || status.scan_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
      end
      ST_ADD: begin
        if (!status.full) begin
          cmd.wr_fill = 1'b1;
        end else if (status.lifo_mode) begin
          cmd.wr_last = 1'b1;
        end else begin
          cmd.lfsr_step = 1'b1;
        end
      end
      ST_REDUCE: begin
        cmd.red_step = 1'b1;
      end
      ST_ADD_RND: begin
        cmd.wr_rem = 1'b1;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/mcrl_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcrl_dp
// Slot memory, fill counter, replacement LFSR, remainder unit, lookup
// comparator and result register.
// ----------------------------------------------------------------------------
module mcrl_dp
  import mcrl_pkg::*;
#(
  parameter int NUM_SLOTS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire dp_cmd_t               cmd,
  output dp_status_t                 status,
  mcrl_in_if.sink                    in_chan,
  mcrl_out_if.source                 out_chan
);

  localparam int SLOT_W   = $clog2(NUM_SLOTS);
  localparam int CNT_W    = $clog2(NUM_SLOTS + 1);
  localparam int RECIP_W  = LFSR_W + 1;
  localparam int RECIP_SH = LFSR_W + SLOT_W;
  localparam int PROD_W   = LFSR_W + RECIP_W;
  localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);
  localparam logic [CNT_W-1:0]   FULL_CNT  = CNT_W'(NUM_SLOTS);
  localparam logic [RECIP_W-1:0] RECIP     =
    RECIP_W'(((1 << RECIP_SH) + NUM_SLOTS - 1) / NUM_SLOTS);
  localparam logic [LFSR_W-1:0]  MOD_N     = LFSR_W'(NUM_SLOTS);

  slot_entry_t mem [NUM_SLOTS];
  slot_entry_t rd_entry_r;

  logic                mode_r;
  logic [LFSR_W-1:0]   lfsr_r;
  logic [CNT_W-1:0]    count_r;
  logic [ID_W-1:0]     id_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [LFSR_W-1:0]   rem_r;
  logic [LFSR_W-1:0]   quot_r;
  logic [CNT_W-1:0]    scan_idx_r;
  logic                cmp_valid_r;
  logic [SLOT_W-1:0]   cmp_idx_r;

  logic                res_hit_r;
  logic [SLOT_W-1:0]   res_slot_r;
  logic [HANDLE_W-1:0] res_handle_r;
  logic                res_repl_r;

  logic                  out_valid_r;
  logic                  out_hit_r;
  logic [SLOT_OUT_W-1:0] out_slot_r;
  logic [HANDLE_W-1:0]   out_handle_r;
  logic                  out_repl_r;
  logic [FILL_OUT_W-1:0] out_fill_r;

  logic                accept;
  logic                wr_en;
  logic [SLOT_W-1:0]   wr_addr;
  logic [SLOT_W-1:0]   rd_addr;
  logic [PROD_W-1:0]   prod;
  logic [SLOT_W-1:0]   rem_val;
  logic                match;
  logic [LFSR_W-1:0]   lfsr_adv;
  logic [SLOT_W+SLOT_OUT_W-1:0] slot_ext;
  logic [CNT_W+FILL_OUT_W-1:0]  fill_ext;

  assign accept   = in_chan.valid & cmd.in_ready;
  assign in_chan.ready = cmd.in_ready;

  assign lfsr_adv = lfsr_next(lfsr_r);
  assign prod     = PROD_W'(rem_r) * PROD_W'(RECIP);
  assign rem_val  = SLOT_W'(rem_r - quot_r * MOD_N);
  assign rd_addr  = scan_idx_r[SLOT_W-1:0];
  assign match    = cmp_valid_r && (rd_entry_r.id == id_r);
  assign slot_ext = {{SLOT_OUT_W{1'b0}}, res_slot_r};
  assign fill_ext = {{FILL_OUT_W{1'b0}}, count_r};

  always_comb begin
    wr_en   = cmd.wr_fill | cmd.wr_last | cmd.wr_rem;
    wr_addr = rem_val;
    if (cmd.wr_fill) begin
      wr_addr = count_r[SLOT_W-1:0];
    end else if (cmd.wr_last) begin
      wr_addr = LAST_SLOT;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= '{id: id_r, handle: handle_r};
    end
    rd_entry_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      lfsr_r  <= SEED_DEFAULT;
      count_r <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_REPLACE_MODE) begin
        mode_r <= cfg_data[0];
      end
      if (cfg_we && cfg_index == REG_RANDOM_SEED) begin
        lfsr_r <= (cfg_data == '0) ? SEED_DEFAULT : cfg_data;
      end else if (cmd.lfsr_step) begin
        lfsr_r <= lfsr_adv;
      end
      if (cmd.wr_fill) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_valid_r <= 1'b0;
    end else if (accept) begin
      cmp_valid_r <= 1'b0;
    end else if (cmd.scan) begin
      cmp_valid_r <= scan_idx_r < count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      id_r         <= in_chan.msg_id;
      handle_r     <= in_chan.msg_handle;
      scan_idx_r   <= '0;
      res_hit_r    <= 1'b0;
      res_slot_r   <= '0;
      res_handle_r <= '0;
      res_repl_r   <= 1'b0;
    end
    if (cmd.wr_fill) begin
      res_slot_r <= count_r[SLOT_W-1:0];
    end
    if (cmd.wr_last) begin
      res_slot_r <= LAST_SLOT;
      res_repl_r <= 1'b1;
    end
    if (cmd.lfsr_step) begin
      rem_r <= lfsr_adv;
    end
    if (cmd.red_step) begin
      quot_r <= LFSR_W'(prod >> RECIP_SH);
    end
    if (cmd.wr_rem) begin
      res_slot_r <= rem_val;
      res_repl_r <= 1'b1;
    end
    if (cmd.scan) begin
      if (scan_idx_r < count_r) begin
        scan_idx_r <= scan_idx_r + 1'b1;
        cmp_idx_r  <= scan_idx_r[SLOT_W-1:0];
      end
      if (match) begin
        res_hit_r    <= 1'b1;
        res_slot_r   <= cmp_idx_r;
        res_handle_r <= rd_entry_r.handle;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_hit_r    <= res_hit_r;
      out_slot_r   <= slot_ext[SLOT_OUT_W-1:0];
      out_handle_r <= res_handle_r;
      out_repl_r   <= res_repl_r;
      out_fill_r   <= fill_ext[FILL_OUT_W-1:0];
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.hit        = out_hit_r;
  assign out_chan.slot       = out_slot_r;
  assign out_chan.handle_out = out_handle_r;
  assign out_chan.replaced   = out_repl_r;
  assign out_chan.fill_level = out_fill_r;

  always_comb begin
    status            = '0;
    status.in_valid   = in_chan.valid;
    status.in_kind    = in_chan.kind;
    status.full       = count_r == FULL_CNT;
    status.lifo_mode  = mode_r;
    status.scan_match = match;
    status.scan_done  = !cmp_valid_r && (scan_idx_r >= count_r);
    status.out_free   = !out_valid_r || out_chan.ready;
  end

endmodule
`default_nettype wire

// ----- sv/message_cache_random_lifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// message_cache_random_lifo
// Fully associative message cache with random or last-slot replacement.
// ----------------------------------------------------------------------------
// One transaction is handled at a time; its result sits in an output register
// so the next request is taken while the result waits. An add to a cache that
// is not full, or any add in LIFO mode, writes its slot in ST_ADD and then
// goes to ST_EMIT. A random replacement advances the LFSR in ST_ADD, then
// reduces its value modulo NUM_SLOTS by a reciprocal multiplication in
// ST_REDUCE and a multiply-back and subtract in ST_ADD_RND, where the slot is
// written. A lookup ends on the first match or once all filled slots, at most
// NUM_SLOTS, are compared, because one comparator walks the slot memory
// through its single read port, one slot per cycle. Configuration writes apply
// at once; the user must make them while the block is idle (not enforced).
module message_cache_random_lifo
  import mcrl_pkg::*;
#(
  parameter int NUM_SLOTS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  mcrl_in_if.sink                    in_chan,
  mcrl_out_if.source                 out_chan
);

  dp_cmd_t    cmd;
  dp_status_t status;

  mcrl_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cmd    (cmd)
  );

  mcrl_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

endmodule
`default_nettype wire

// ----- sv/mcrl_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcrl_checker
// Port-level checks on result transactions of the message cache.
// ----------------------------------------------------------------------------
module mcrl_checker
  import mcrl_pkg::*;
#(
  parameter int NUM_SLOTS = 16
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic                  out_hit,
  input wire logic [SLOT_OUT_W-1:0] out_slot,
  input wire logic [HANDLE_W-1:0]   out_handle_out,
  input wire logic                  out_replaced,
  input wire logic [FILL_OUT_W-1:0] out_fill_level
);

  localparam logic [FILL_OUT_W-1:0] FULL_LEVEL = FILL_OUT_W'(NUM_SLOTS);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slot) && $stable(out_handle_out)
      && $stable(out_hit) && $stable(out_fill_level))
    else $error("Stalled result transaction changed.");

  a_miss_handle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_handle_out == '0)
    else $error("Handle returned without a hit.");

  a_hit_not_replaced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_replaced)
    else $error("Lookup hit flagged as a replacement.");

  a_replace_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_replaced |-> out_fill_level == FULL_LEVEL)
    else $error("Replacement reported while the cache was not full.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

endmodule

bind message_cache_random_lifo mcrl_checker #(
  .NUM_SLOTS (NUM_SLOTS)
) u_mcrl_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_hit        (out_chan.hit),
  .out_slot       (out_chan.slot),
  .out_handle_out (out_chan.handle_out),
  .out_replaced   (out_chan.replaced),
  .out_fill_level (out_chan.fill_level)
);
`default_nettype wire

// ----- tb/sv/mcrl_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcrl_result_checker
// Watches the request, result and register ports of the message cache. It
// keeps its own copy of the slot store, fill count, LFSR and registers,
// predicts the result of every accepted request, and compares each accepted
// result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module mcrl_result_checker
  import mcrl_pkg::*;
#(
  parameter int NUM_SLOTS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  mcrl_in_if                    req_mon,
  mcrl_out_if                   res_mon,
  output int                    fail_count,
  output int                    pending_results
);

  typedef struct packed {
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot;
    logic [HANDLE_W-1:0]   handle_out;
    logic                  replaced;
    logic [FILL_OUT_W-1:0] fill_level;
  } cache_result_t;

  logic [ID_W-1:0]     model_ids[NUM_SLOTS];
  logic [HANDLE_W-1:0] model_handles[NUM_SLOTS];
  int                  model_fill;
  logic [LFSR_W-1:0]   model_lfsr;
  logic                model_lifo;
  cache_result_t       expected_results[$];

  function automatic cache_result_t predict_cache(input logic kind, input logic [ID_W-1:0] id,
                                                  input logic [HANDLE_W-1:0] handle);
    cache_result_t res;
    int            target;
    logic          found;
    res    = '0;
    target = 0;
    found  = 1'b0;
    if (kind == KIND_ADD) begin
      if (model_fill < NUM_SLOTS) begin
        target     = model_fill;
        model_fill = model_fill + 1;
      end else begin
        if (model_lifo) begin
          target = NUM_SLOTS - 1;
        end else begin
          model_lfsr = model_lfsr[0] ? ((model_lfsr >> 1) ^ LFSR_TAPS) : (model_lfsr >> 1);
          target     = int'(model_lfsr) % NUM_SLOTS;
        end
        res.replaced = 1'b1;
      end
      model_ids[target]     = id;
      model_handles[target] = handle;
      res.slot              = target[SLOT_OUT_W-1:0];
    end else begin
      for (int i = 0; i < model_fill; i++) begin
        if (!found && model_ids[i] == id) begin
          found          = 1'b1;
          res.hit        = 1'b1;
          res.slot       = i[SLOT_OUT_W-1:0];
          res.handle_out = model_handles[i];
        end
      end
    end
    res.fill_level = model_fill[FILL_OUT_W-1:0];
    return res;
  endfunction

  function automatic int field_mismatch(input string name, input logic [HANDLE_W-1:0] exp_val,
                                        input logic [HANDLE_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    cache_result_t exp_res;
    int            errs;
    if (!rst_n) begin
      model_fill      = 0;
      model_lifo      = 1'b0;
      model_lfsr      = SEED_DEFAULT;
      fail_count      = 0;
      expected_results.delete();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        model_ids[i]     = '0;
        model_handles[i] = '0;
      end
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (expected_results.size() == 0) begin
          $error("Result transaction arrived with no request outstanding.");
          fail_count = fail_count + 1;
        end else begin
          exp_res = expected_results.pop_front();
          errs = 0;
          errs += field_mismatch("hit", 32'(exp_res.hit), 32'(res_mon.hit));
          errs += field_mismatch("slot", 32'(exp_res.slot), 32'(res_mon.slot));
          errs += field_mismatch("handle_out", exp_res.handle_out, res_mon.handle_out);
          errs += field_mismatch("replaced", 32'(exp_res.replaced), 32'(res_mon.replaced));
          errs += field_mismatch("fill_level", 32'(exp_res.fill_level), 32'(res_mon.fill_level));
          if (errs != 0) begin
            fail_count = fail_count + 1;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_REPLACE_MODE) begin
          model_lifo = cfg_data[0];
        end else if (cfg_index == REG_RANDOM_SEED) begin
          model_lfsr = (cfg_data == '0) ? SEED_DEFAULT : cfg_data;
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        expected_results.push_back(predict_cache(req_mon.kind, req_mon.msg_id,
                                                 req_mon.msg_handle));
      end
    end
    pending_results = expected_results.size();
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the message cache. A directed opening covers the
// empty, partly filled and full cache, duplicate ids, id and handle extremes,
// both replacement modes and the zero seed. Random phases then run under
// several register settings, with random idling on both sides, one stretch
// without idling and one long hold-off of the result side.
// ----------------------------------------------------------------------------
module tb;
  import mcrl_pkg::*;

  localparam int NUM_SLOTS    = 16;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 130;
  localparam int HOLD_CYCLES  = 80;
  localparam int SETTLE_WAIT  = 24;
  localparam int POOL_SIZE    = 8;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending_results;
  int                    cycle_count;
  logic                  calm;
  logic                  hold_go;
  logic                  hold_done;
  int                    hold_count;
  logic [ID_W-1:0]       id_pool[POOL_SIZE];

  mcrl_in_if  req_chan ();
  mcrl_out_if res_chan ();

  message_cache_random_lifo #(
    .NUM_SLOTS(NUM_SLOTS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_chan  (req_chan),
    .out_chan (res_chan)
  );

  mcrl_result_checker #(
    .NUM_SLOTS(NUM_SLOTS)
  ) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .req_mon        (req_chan),
    .res_mon        (res_chan),
    .fail_count     (fail_count),
    .pending_results(pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // The result side counts its own hold-off once the stimulus asks for it.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        res_chan.ready = 1'b0;
        hold_count = hold_count + 1;
        if (hold_count >= HOLD_CYCLES) begin
          hold_done = 1'b1;
        end
      end else if (calm) begin
        res_chan.ready = 1'b1;
      end else begin
        res_chan.ready = ($urandom_range(99) >= 20);
      end
    end
  end

  // Entered at a rising edge; returns at the rising edge of acceptance.
  task automatic send_req(input logic kind, input logic [ID_W-1:0] id,
                          input logic [HANDLE_W-1:0] handle);
    @(negedge clk);
    if (!calm && $urandom_range(99) < 20) begin
      req_chan.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    req_chan.valid      = 1'b1;
    req_chan.kind       = kind;
    req_chan.msg_id     = id;
    req_chan.msg_handle = handle;
    @(posedge clk);
    while (!req_chan.ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    req_chan.valid = 1'b0;
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random_phase(input logic lifo, input logic [CFG_DATA_W-1:0] seed,
                                  input logic quiet, input logic with_hold);
    logic            kind;
    logic [ID_W-1:0] id;
    write_reg(REG_REPLACE_MODE, 16'(lifo));
    write_reg(REG_RANDOM_SEED, seed);
    for (int i = 0; i < POOL_SIZE; i++) begin
      id_pool[i] = ID_W'($urandom);
    end
    id_pool[0] = '0;
    id_pool[1] = '1;
    calm = quiet;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (with_hold && n == 40) begin
        hold_go = 1'b1;
      end
      kind = ($urandom_range(99) < 55) ? KIND_ADD : KIND_LOOKUP;
      if ($urandom_range(99) < 75) begin
        id = id_pool[$urandom_range(POOL_SIZE - 1)];
      end else begin
        id = ID_W'($urandom);
      end
      send_req(kind, id, $urandom);
    end
    calm = 1'b0;
  endtask

  initial begin
    cycle_count         = 0;
    calm                = 1'b0;
    hold_go             = 1'b0;
    hold_done           = 1'b0;
    hold_count          = 0;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = REG_REPLACE_MODE;
    cfg_data            = '0;
    req_chan.valid      = 1'b0;
    req_chan.kind       = KIND_ADD;
    req_chan.msg_id     = '0;
    req_chan.msg_handle = '0;
    res_chan.ready      = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // Directed opening under reset settings: random mode, default seed.
    send_req(KIND_LOOKUP, 31'd5, 32'h1234_5678);
    send_req(KIND_ADD, '0, '0);
    send_req(KIND_ADD, '1, '1);
    send_req(KIND_ADD, 31'h0001_2345, 32'hA5A5_A5A5);
    send_req(KIND_ADD, 31'h0001_2345, 32'h5A5A_5A5A);
    send_req(KIND_LOOKUP, 31'h0001_2345, '0);
    send_req(KIND_LOOKUP, '1, '0);
    send_req(KIND_LOOKUP, '0, '1);
    send_req(KIND_LOOKUP, 31'h0000_0555, '0);
    for (int i = 0; i < NUM_SLOTS - 4; i++) begin
      send_req(KIND_ADD, ID_W'(100 + i), 32'hC000_0000 + i);
    end
    send_req(KIND_ADD, 31'h2AAA_AAAA, 32'h5555_5555);
    send_req(KIND_LOOKUP, 31'h2AAA_AAAA, '0);
    write_reg(REG_REPLACE_MODE, 16'd1);
    send_req(KIND_ADD, 31'h5555_5555, 32'hAAAA_AAAA);
    send_req(KIND_LOOKUP, 31'h5555_5555, '0);
    write_reg(REG_REPLACE_MODE, 16'd0);
    write_reg(REG_RANDOM_SEED, 16'd0);
    send_req(KIND_ADD, 31'h0F0F_0F0F, 32'hF0F0_F0F0);

    run_random_phase(1'b0, 16'($urandom_range(1, 65535)), 1'b0, 1'b1);
    run_random_phase(1'b1, 16'd1, 1'b1, 1'b0);
    run_random_phase(1'b0, 16'd1, 1'b0, 1'b0);
    run_random_phase(1'b0, 16'hFFFF, 1'b0, 1'b0);
    run_random_phase(1'b0, 16'd0, 1'b0, 1'b0);

    @(negedge clk);
    req_chan.valid = 1'b0;
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
